// File: hdl/smcc_pkg.sv
package smcc_pkg;

   // Default sizes handed to the top level.
   localparam int CHANNELS_DEF     = 4;
   localparam int FILTER_DEPTH_DEF = 8;
   localparam int ADC_BITS_DEF     = 12;

   // Fixed field widths of the ports.
   localparam int CH_W     = 2;
   localparam int SMP_W    = 12;
   localparam int CAL_W    = 12;
   localparam int CSR_W    = 2 * CAL_W;
   localparam int IDX_W    = 3;
   localparam int MASK_W   = 4;
   localparam int CAL_REGS = 4;
   localparam int MOIST_W  = 14;
   localparam int CLASS_W  = 3;
   localparam int DIAG_W   = 2;

   // Register reset values.
   localparam logic [MASK_W-1:0] ACTIVE_MASK_RST = 4'hF;
   localparam logic [CAL_W-1:0]  DEF_DRY_RST     = 12'd3000;
   localparam logic [CAL_W-1:0]  DEF_WET_RST     = 12'd1200;

   // Moisture scale and class thresholds, in hundredths of a percent.
   localparam logic [MOIST_W-1:0] MOIST_FULL = 14'd10000;
   localparam logic [MOIST_W-1:0] TH_LOW     = 14'd2000;
   localparam logic [MOIST_W-1:0] TH_OPTIMAL = 14'd4000;
   localparam logic [MOIST_W-1:0] TH_HIGH    = 14'd7000;
   localparam logic [MOIST_W-1:0] TH_SAT     = 14'd9000;

   // Distance from either end of the ADC range that flags a wiring fault.
   localparam int DIAG_MARGIN = 10;

   // Operation codes of an input item.
   localparam logic FUNC_SAMPLE = 1'b0;
   localparam logic FUNC_PRIME  = 1'b1;

   // Register indexes of the configuration port.
   localparam logic [IDX_W-1:0] REG_CAL_CH0     = 3'd0;
   localparam logic [IDX_W-1:0] REG_CAL_CH1     = 3'd1;
   localparam logic [IDX_W-1:0] REG_CAL_CH2     = 3'd2;
   localparam logic [IDX_W-1:0] REG_CAL_CH3     = 3'd3;
   localparam logic [IDX_W-1:0] REG_CAL_MASK    = 3'd4;
   localparam logic [IDX_W-1:0] REG_ACTIVE_MASK = 3'd5;
   localparam logic [IDX_W-1:0] REG_DEF_DRY     = 3'd6;
   localparam logic [IDX_W-1:0] REG_DEF_WET     = 3'd7;

   typedef enum logic [CLASS_W-1:0] {
      CLASS_DRY       = 3'd0,
      CLASS_LOW       = 3'd1,
      CLASS_OPTIMAL   = 3'd2,
      CLASS_HIGH      = 3'd3,
      CLASS_SATURATED = 3'd4,
      CLASS_INACTIVE  = 3'd5
   } moisture_class_type;

   typedef enum logic [DIAG_W-1:0] {
      DIAG_OK            = 2'd0,
      DIAG_NOT_CONNECTED = 2'd1,
      DIAG_SHORT         = 2'd2,
      DIAG_UNCALIBRATED  = 2'd3
   } diagnosis_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_PRIME,
      ST_UPDATE,
      ST_DIFF,
      ST_MULT,
      ST_DIV_START,
      ST_DIV_WAIT,
      ST_FINISH
   } state_type;

   // Five-level moisture class of an active channel.
   function automatic moisture_class_type class_of(input logic [MOIST_W-1:0] moist);
      moisture_class_type cls;
      priority if (moist < TH_LOW) begin
         cls = CLASS_DRY;
      end else if (moist < TH_OPTIMAL) begin
         cls = CLASS_LOW;
      end else if (moist < TH_HIGH) begin
         cls = CLASS_OPTIMAL;
      end else if (moist < TH_SAT) begin
         cls = CLASS_HIGH;
      end else begin
         cls = CLASS_SATURATED;
      end
      return cls;
   endfunction

endpackage

// File: hdl/smcc_ram.sv
module smcc_ram #(
   parameter int WIDTH = 12,
   parameter int DEPTH = 32,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              we,
   input  logic [ADDR_W-1:0] waddr,
   input  logic [WIDTH-1:0]  wdata,
   input  logic [ADDR_W-1:0] raddr,
   output logic [WIDTH-1:0]  rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // One write port and one registered read port.
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// File: hdl/smcc_div.sv
module smcc_div #(
   parameter int NUM_W = 16,
   parameter int DEN_W = 8,
   parameter int Q_W   = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [NUM_W-1:0] num,
   input  logic [DEN_W-1:0] den,
   output logic             busy,
   output logic [Q_W-1:0]   quo
);

   localparam int CNT_W = $clog2(Q_W + 1);

   logic [DEN_W-1:0] rem_ff;
   logic [DEN_W-1:0] den_ff;
   logic [Q_W-1:0]   bits_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic             busy_ff;
   logic [DEN_W:0]   trial;
   logic             take;

   // The caller guarantees num < den * 2**Q_W, so the high part of num is
   // already a valid partial remainder and only Q_W steps remain.
   assign trial = {rem_ff, bits_ff[Q_W-1]};
   assign take  = (trial >= {1'b0, den_ff});

   // Control: one quotient bit per cycle.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (start) begin
         busy_ff <= 1'b1;
         cnt_ff  <= CNT_W'(Q_W);
      end else if (busy_ff) begin
         cnt_ff <= cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_ff <= 1'b0;
         end
      end
   end

   // Datapath: restoring division; the low numerator bits shift out as the
   // quotient bits shift in.
   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff  <= DEN_W'(num >> Q_W);
         bits_ff <= num[Q_W-1:0];
         den_ff  <= den;
      end else if (busy_ff) begin
         rem_ff  <= take ? DEN_W'(trial - {1'b0, den_ff}) : DEN_W'(trial);
         bits_ff <= {bits_ff[Q_W-2:0], take};
      end
   end

   assign busy = busy_ff;
   assign quo  = bits_ff;

endmodule

// File: hdl/soil_moisture_channel_conditioner.sv
// Channel  Direction  Handshake              Payload
// req      in         req_valid/req_ready    req_func, req_channel, req_sample
// rsp      out        rsp_valid/rsp_ready    valid_res, channel_out, level, moisture,
//                                            bad_calibration, class, diagnosis
// csr      in         csr_we                 csr_index, csr_wdata
//
// A sample item on an active channel passes the update, difference, multiply and
// divider-start states, waits for the 14-step moisture divider and is registered
// in the finish state; an inactive channel goes straight there. A prime item
// fills all FILTER_DEPTH ring entries of its channel. After reset the ring is
// cleared one entry a cycle with req_ready low. A stalled result waits in the
// output register while the next item is worked on; that item holds in finish.
module soil_moisture_channel_conditioner #(
   parameter int CHANNELS     = smcc_pkg::CHANNELS_DEF,
   parameter int FILTER_DEPTH = smcc_pkg::FILTER_DEPTH_DEF,
   parameter int ADC_BITS     = smcc_pkg::ADC_BITS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic                         req_func,
   input  logic [smcc_pkg::CH_W-1:0]    req_channel,
   input  logic [smcc_pkg::SMP_W-1:0]   req_sample,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic                         rsp_valid_res,
   output logic [smcc_pkg::CH_W-1:0]    rsp_channel_out,
   output logic [smcc_pkg::SMP_W-1:0]   rsp_filtered_level,
   output logic [smcc_pkg::MOIST_W-1:0] rsp_moisture_x100,
   output logic                         rsp_bad_calibration,
   output logic [smcc_pkg::CLASS_W-1:0] rsp_moisture_class,
   output logic [smcc_pkg::DIAG_W-1:0]  rsp_diagnosis,
   input  logic                         csr_we,
   input  logic [smcc_pkg::IDX_W-1:0]   csr_index,
   input  logic [smcc_pkg::CSR_W-1:0]   csr_wdata
);

   import smcc_pkg::*;

   localparam int LOG_D     = (FILTER_DEPTH > 1) ? $clog2(FILTER_DEPTH) : 1;
   localparam int POS_W     = LOG_D;
   localparam int SUM_W     = ADC_BITS + LOG_D;
   localparam int RING_N    = CHANNELS * FILTER_DEPTH;
   localparam int ADDR_W    = (RING_N > 1) ? $clog2(RING_N) : 1;
   localparam int CH_IDX_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int DW        = CAL_W + LOG_D;
   localparam int CMP_W     = ((SUM_W > DW) ? SUM_W : DW) + 1;
   localparam int NUM_W     = DW + MOIST_W;
   localparam int LVL_SH    = SUM_W + LOG_D;
   localparam int RCP_W     = SUM_W + 2;
   localparam int PROD_W    = SUM_W + RCP_W;
   localparam longint RCP_VAL = ((longint'(1) << LVL_SH) + longint'(FILTER_DEPTH)
                                 - longint'(1)) / longint'(FILTER_DEPTH);
   localparam logic [RCP_W-1:0] LVL_RCP = RCP_W'(RCP_VAL);
   localparam logic [ADC_BITS-1:0] LVL_HIGH  = ADC_BITS'((1 << ADC_BITS) - 1 - DIAG_MARGIN);
   localparam logic [ADC_BITS-1:0] LVL_SHORT = ADC_BITS'(DIAG_MARGIN);

   // Configuration registers.
   logic [CSR_W-1:0]  cal_ff [CAL_REGS];
   logic [MASK_W-1:0] cal_mask_ff;
   logic [MASK_W-1:0] active_mask_ff;
   logic [CAL_W-1:0]  def_dry_ff;
   logic [CAL_W-1:0]  def_wet_ff;

   // Per-channel ring bookkeeping.
   logic [POS_W-1:0] wr_pos_ff [CHANNELS];
   logic [SUM_W-1:0] ring_sum_ff [CHANNELS];

   // Sequencer and item registers.
   state_type          state_ff, state_in;
   logic [ADDR_W-1:0]  clr_ff;
   logic [POS_W-1:0]   cnt_ff;
   logic               act_ff;
   logic               calib_ff;
   logic               inv_ff;
   logic [CH_W-1:0]    ch_ff;
   logic [CH_IDX_W-1:0] chi_ff;
   logic [ADC_BITS-1:0] smp_ff;
   logic [ADDR_W-1:0]  base_ff;
   logic [ADDR_W-1:0]  addr_ff;
   logic [DW-1:0]      dryd_ff;
   logic [DW-1:0]      den_ff;
   logic [SUM_W-1:0]   sum_new_ff;
   logic signed [CMP_W-1:0] diff_ff;
   logic               zero_ff;
   logic               full_ff;
   logic [NUM_W-1:0]   num_ff;

   // Output register.
   logic                         rsp_valid_ff;
   logic                         rsp_valid_res_ff;
   logic [CH_W-1:0]              rsp_channel_out_ff;
   logic [SMP_W-1:0]             rsp_level_ff;
   logic [MOIST_W-1:0]           rsp_moist_ff;
   logic                         rsp_bad_ff;
   moisture_class_type           rsp_class_ff;
   diagnosis_type                rsp_diag_ff;

   // Combinational signals.
   logic                accept;
   logic                in_range;
   logic [CH_IDX_W-1:0] req_chi;
   logic [CAL_W-1:0]    dry_sel;
   logic [CAL_W-1:0]    wet_sel;
   logic                calib_sel;
   logic [ADDR_W-1:0]   req_base;
   logic [ADDR_W-1:0]   rd_addr;
   logic                ram_we;
   logic [ADDR_W-1:0]   ram_waddr;
   logic [ADC_BITS-1:0] ram_wdata;
   logic [ADC_BITS-1:0] ram_rdata;
   logic                div_start;
   logic                rsp_load;
   logic [SUM_W-1:0]    sum_upd;
   logic signed [CMP_W-1:0] diff_c;
   logic                mst_busy;
   logic [PROD_W-1:0]   lvl_prod;
   logic [ADC_BITS-1:0] lvl_quo;
   logic [MOIST_W-1:0]  mst_quo;
   logic [MOIST_W-1:0]  moist_c;
   diagnosis_type       diag_c;
   logic                prime_last;
   logic                clr_last;
   logic [POS_W-1:0]    pos_next;

   // Decode of the incoming item.
   assign accept    = req_valid && req_ready;
   assign in_range  = (int'(req_channel) < CHANNELS);
   assign req_chi   = CH_IDX_W'(req_channel);
   assign calib_sel = cal_mask_ff[req_channel];
   assign dry_sel   = calib_sel ? cal_ff[req_channel][CSR_W-1:CAL_W] : def_dry_ff;
   assign wet_sel   = calib_sel ? cal_ff[req_channel][CAL_W-1:0] : def_wet_ff;
   assign req_base  = ADDR_W'(req_chi) * ADDR_W'(FILTER_DEPTH);
   assign rd_addr   = req_base + ADDR_W'(wr_pos_ff[req_chi]);

   assign prime_last = (cnt_ff == POS_W'(FILTER_DEPTH - 1));
   assign clr_last   = (clr_ff == ADDR_W'(RING_N - 1));
   assign pos_next   = (wr_pos_ff[chi_ff] == POS_W'(FILTER_DEPTH - 1)) ? '0
                       : wr_pos_ff[chi_ff] + POS_W'(1);

   // Configuration writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < CAL_REGS; i++) begin
            cal_ff[i] <= '0;
         end
         cal_mask_ff    <= '0;
         active_mask_ff <= ACTIVE_MASK_RST;
         def_dry_ff     <= DEF_DRY_RST;
         def_wet_ff     <= DEF_WET_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            REG_CAL_CH0,
            REG_CAL_CH1,
            REG_CAL_CH2,
            REG_CAL_CH3:     cal_ff[csr_index[1:0]] <= csr_wdata;
            REG_CAL_MASK:    cal_mask_ff <= csr_wdata[MASK_W-1:0];
            REG_ACTIVE_MASK: active_mask_ff <= csr_wdata[MASK_W-1:0];
            REG_DEF_DRY:     def_dry_ff <= csr_wdata[CAL_W-1:0];
            REG_DEF_WET:     def_wet_ff <= csr_wdata[CAL_W-1:0];
            default: ;
         endcase
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (clr_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               if (req_func == FUNC_PRIME) begin
                  state_in = in_range ? ST_PRIME : ST_IDLE;
               end else begin
                  state_in = (in_range && active_mask_ff[req_channel]) ? ST_UPDATE
                             : ST_FINISH;
               end
            end
         end
         ST_PRIME: begin
            if (prime_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_UPDATE:    state_in = ST_DIFF;
         ST_DIFF:      state_in = ST_MULT;
         ST_MULT:      state_in = ST_DIV_START;
         ST_DIV_START: state_in = ST_DIV_WAIT;
         ST_DIV_WAIT: begin
            if (!mst_busy) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_CLEAR;
      endcase
   end

   // Control outputs of the sequencer.
   always_comb begin
      req_ready = 1'b0;
      ram_we    = 1'b0;
      ram_waddr = addr_ff;
      ram_wdata = smp_ff;
      div_start = 1'b0;
      rsp_load  = 1'b0;
      unique case (state_ff)
         ST_CLEAR: begin
            ram_we    = 1'b1;
            ram_waddr = clr_ff;
            ram_wdata = '0;
         end
         ST_IDLE:  req_ready = 1'b1;
         ST_PRIME: begin
            ram_we    = 1'b1;
            ram_waddr = base_ff + ADDR_W'(cnt_ff);
         end
         ST_UPDATE:    ram_we = 1'b1;
         ST_DIV_START: div_start = 1'b1;
         ST_FINISH:    rsp_load = !rsp_valid_ff || rsp_ready;
         default: ;
      endcase
   end

   // Sequencer state and sweep counters.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clr_ff   <= '0;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         if (state_ff == ST_CLEAR) begin
            clr_ff <= clr_ff + ADDR_W'(1);
         end
         if (state_ff == ST_PRIME) begin
            cnt_ff <= cnt_ff + POS_W'(1);
         end else begin
            cnt_ff <= '0;
         end
      end
   end

   // Ring bookkeeping: a prime zeroes the position and fills the sum; a sample advances.
   assign sum_upd = ring_sum_ff[chi_ff] - SUM_W'(ram_rdata) + SUM_W'(smp_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < CHANNELS; i++) begin
            wr_pos_ff[i]   <= '0;
            ring_sum_ff[i] <= '0;
         end
      end else if (accept && req_func == FUNC_PRIME && in_range) begin
         wr_pos_ff[req_chi]   <= '0;
         ring_sum_ff[req_chi] <= SUM_W'(ADC_BITS'(req_sample)) * SUM_W'(FILTER_DEPTH);
      end else if (state_ff == ST_UPDATE) begin
         wr_pos_ff[chi_ff]   <= pos_next;
         ring_sum_ff[chi_ff] <= sum_upd;
      end
   end

   // Item capture and the arithmetic ahead of the divider.
   assign diff_c = $signed(CMP_W'(dryd_ff)) - $signed(CMP_W'(sum_new_ff));

   always_ff @(posedge clock) begin
      if (accept) begin
         act_ff   <= in_range && active_mask_ff[req_channel];
         calib_ff <= calib_sel;
         inv_ff   <= (wet_sel >= dry_sel);
         ch_ff    <= req_channel;
         chi_ff   <= req_chi;
         smp_ff   <= ADC_BITS'(req_sample);
         base_ff  <= req_base;
         addr_ff  <= rd_addr;
         dryd_ff  <= DW'(dry_sel) * DW'(FILTER_DEPTH);
         den_ff   <= DW'(dry_sel - wet_sel) * DW'(FILTER_DEPTH);
      end
      if (state_ff == ST_UPDATE) begin
         sum_new_ff <= sum_upd;
      end
      if (state_ff == ST_DIFF) begin
         diff_ff <= diff_c;
         zero_ff <= inv_ff || (diff_c <= 0);
         full_ff <= (diff_c >= $signed(CMP_W'(den_ff)));
      end
      if (state_ff == ST_MULT) begin
         num_ff <= NUM_W'(diff_ff[DW-1:0]) * NUM_W'(MOIST_FULL);
      end
   end

   smcc_ram #(
      .WIDTH (ADC_BITS),
      .DEPTH (RING_N)
   ) u_ring (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (rd_addr),
      .rdata (ram_rdata)
   );

   // Ring average: the sum times the rounded-up reciprocal of the depth, which is
   // exact over the whole range of the sum.
   assign lvl_prod = PROD_W'(sum_new_ff) * PROD_W'(LVL_RCP);
   assign lvl_quo  = ADC_BITS'(lvl_prod >> LVL_SH);

   // Calibration ratio, used only between zero and full scale.
   smcc_div #(
      .NUM_W (NUM_W),
      .DEN_W (DW),
      .Q_W   (MOIST_W)
   ) u_div_moist (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (num_ff),
      .den   (den_ff),
      .busy  (mst_busy),
      .quo   (mst_quo)
   );

   // Final moisture and diagnosis of an active channel.
   always_comb begin
      priority if (zero_ff) begin
         moist_c = '0;
      end else if (full_ff) begin
         moist_c = MOIST_FULL;
      end else begin
         moist_c = mst_quo;
      end
      priority if (lvl_quo >= LVL_HIGH) begin
         diag_c = DIAG_NOT_CONNECTED;
      end else if (lvl_quo < LVL_SHORT) begin
         diag_c = DIAG_SHORT;
      end else if (!calib_ff) begin
         diag_c = DIAG_UNCALIBRATED;
      end else begin
         diag_c = DIAG_OK;
      end
   end

   // Output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_valid_res_ff   <= act_ff;
         rsp_channel_out_ff <= ch_ff;
         if (act_ff) begin
            rsp_level_ff <= SMP_W'(lvl_quo);
            rsp_moist_ff <= moist_c;
            rsp_bad_ff   <= inv_ff && calib_ff;
            rsp_class_ff <= class_of(moist_c);
            rsp_diag_ff  <= diag_c;
         end else begin
            rsp_level_ff <= '0;
            rsp_moist_ff <= '0;
            rsp_bad_ff   <= 1'b0;
            rsp_class_ff <= CLASS_INACTIVE;
            rsp_diag_ff  <= DIAG_NOT_CONNECTED;
         end
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_valid_res       = rsp_valid_res_ff;
   assign rsp_channel_out     = rsp_channel_out_ff;
   assign rsp_filtered_level  = rsp_level_ff;
   assign rsp_moisture_x100   = rsp_moist_ff;
   assign rsp_bad_calibration = rsp_bad_ff;
   assign rsp_moisture_class  = rsp_class_ff;
   assign rsp_diagnosis       = rsp_diag_ff;

endmodule

// File: hdl/smcc_checker.sv
module smcc_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_valid,
   input logic                         req_ready,
   input logic                         req_func,
   input logic                         rsp_valid,
   input logic                         rsp_ready,
   input logic                         rsp_valid_res,
   input logic [smcc_pkg::CH_W-1:0]    rsp_channel_out,
   input logic [smcc_pkg::MOIST_W-1:0] rsp_moisture_x100,
   input logic                         rsp_bad_calibration,
   input logic [smcc_pkg::CLASS_W-1:0] rsp_moisture_class,
   input logic [smcc_pkg::DIAG_W-1:0]  rsp_diagnosis
);

   import smcc_pkg::*;

   // A result that is not taken stays put.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_moisture_x100)
         && $stable(rsp_channel_out) && $stable(rsp_diagnosis))
      else $error("stalled result changed");

   // A sample item is worked on alone: no second item in the next cycle.
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_func == FUNC_SAMPLE |=> !req_ready)
      else $error("item accepted while a sample was in progress");

   // The moisture figure never leaves its scale.
   a_moist_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_moisture_x100 <= MOIST_FULL)
      else $error("moisture above full scale");

   // An inactive channel reports the fixed inactive pattern.
   a_inactive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_valid_res |-> rsp_moisture_class == CLASS_INACTIVE
         && rsp_diagnosis == DIAG_NOT_CONNECTED && rsp_moisture_x100 == '0
         && !rsp_bad_calibration)
      else $error("inactive result carries data");

   // An inverted calibration forces zero moisture and the dry class.
   a_bad_cal: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_bad_calibration |-> rsp_valid_res
         && rsp_moisture_x100 == '0 && rsp_moisture_class == CLASS_DRY)
      else $error("bad calibration with nonzero moisture");

endmodule

bind soil_moisture_channel_conditioner smcc_checker u_smcc_checker (.*);

// File: verif/smcc_reading_check.sv
`timescale 1ns / 100ps

// Watches the request, result and register ports of the conditioner, predicts
// every reading from its own copy of the rings and registers, and compares
// each returned reading with the oldest prediction.
module smcc_reading_check import smcc_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_ready,
   input  logic               req_func,
   input  logic [CH_W-1:0]    req_channel,
   input  logic [SMP_W-1:0]   req_sample,
   input  logic               rsp_valid,
   input  logic               rsp_ready,
   input  logic               rsp_valid_res,
   input  logic [CH_W-1:0]    rsp_channel_out,
   input  logic [SMP_W-1:0]   rsp_filtered_level,
   input  logic [MOIST_W-1:0] rsp_moisture_x100,
   input  logic               rsp_bad_calibration,
   input  logic [CLASS_W-1:0] rsp_moisture_class,
   input  logic [DIAG_W-1:0]  rsp_diagnosis,
   input  logic               csr_we,
   input  logic [IDX_W-1:0]   csr_index,
   input  logic [CSR_W-1:0]   csr_wdata,
   output int                 failures,
   output int                 readings_due
);

   localparam int NCH        = CHANNELS_DEF;
   localparam int DEPTH      = FILTER_DEPTH_DEF;
   localparam int FULL_SCALE = (1 << ADC_BITS_DEF) - 1;
   localparam int REPORT_MAX = 10;

   typedef struct packed {
      logic               valid_res;
      logic [CH_W-1:0]    channel;
      logic [SMP_W-1:0]   level;
      logic [MOIST_W-1:0] moisture;
      logic               bad_cal;
      moisture_class_type cls;
      diagnosis_type      diag;
   } reading_t;

   // Mirror of the block's rings and registers.
   logic [SMP_W-1:0]  ring [NCH][DEPTH];
   int unsigned       wr_pos [NCH];
   int unsigned       ring_total [NCH];
   logic [CSR_W-1:0]  cal [CAL_REGS];
   logic [MASK_W-1:0] cal_mask;
   logic [MASK_W-1:0] act_mask;
   logic [CAL_W-1:0]  dflt_dry;
   logic [CAL_W-1:0]  dflt_wet;

   reading_t pending_readings [$];

   function automatic string describe(input reading_t r);
      return $sformatf("valid %0d ch %0d level %0d moisture %0d bad %0d class %0d diag %0d",
                       r.valid_res, r.channel, r.level, r.moisture, r.bad_cal, r.cls, r.diag);
   endfunction

   // Fill a channel ring with one value and restart its write position.
   function automatic void prime_ring(input int ch, input logic [SMP_W-1:0] smp);
      for (int i = 0; i < DEPTH; i++) begin
         ring[ch][i] = smp;
      end
      ring_total[ch] = smp * DEPTH;
      wr_pos[ch] = 0;
   endfunction

   // Store one sample, average the ring and map it through the calibration.
   function automatic reading_t condition_sample(input logic [CH_W-1:0] ch,
                                                 input logic [SMP_W-1:0] smp);
      reading_t    r;
      logic        calibrated;
      int unsigned pos;
      int unsigned level;
      int unsigned dry;
      int unsigned wet;
      longint      num;
      longint      den;
      longint      q;
      r = '0;
      r.channel = ch;
      if (ch >= NCH || !act_mask[ch]) begin
         r.cls  = CLASS_INACTIVE;
         r.diag = DIAG_NOT_CONNECTED;
         return r;
      end

      pos = wr_pos[ch] % DEPTH;
      ring_total[ch] = ring_total[ch] - ring[ch][pos] + smp;
      ring[ch][pos] = smp;
      wr_pos[ch] = (pos + 1) % DEPTH;
      level = ring_total[ch] / DEPTH;

      calibrated = cal_mask[ch];
      if (calibrated) begin
         dry = cal[ch][CSR_W-1:CAL_W];
         wet = cal[ch][CAL_W-1:0];
      end else begin
         dry = dflt_dry;
         wet = dflt_wet;
      end

      // Exact rational mapping on the ring sum; an inverted pair reads as dry.
      r.moisture = '0;
      if (wet >= dry) begin
         r.bad_cal = calibrated;
      end else begin
         num = 64'sd10000 * (longint'(dry) * DEPTH - longint'(ring_total[ch]));
         den = longint'(dry - wet) * DEPTH;
         if (num > 0) begin
            q = num / den;
            r.moisture = (q > MOIST_FULL) ? MOIST_FULL : MOIST_W'(q);
         end
      end

      if (r.moisture < TH_LOW) begin
         r.cls = CLASS_DRY;
      end else if (r.moisture < TH_OPTIMAL) begin
         r.cls = CLASS_LOW;
      end else if (r.moisture < TH_HIGH) begin
         r.cls = CLASS_OPTIMAL;
      end else if (r.moisture < TH_SAT) begin
         r.cls = CLASS_HIGH;
      end else begin
         r.cls = CLASS_SATURATED;
      end

      if (level >= FULL_SCALE - DIAG_MARGIN) begin
         r.diag = DIAG_NOT_CONNECTED;
      end else if (level < DIAG_MARGIN) begin
         r.diag = DIAG_SHORT;
      end else if (!calibrated) begin
         r.diag = DIAG_UNCALIBRATED;
      end else begin
         r.diag = DIAG_OK;
      end

      r.valid_res = 1'b1;
      r.level     = SMP_W'(level);
      return r;
   endfunction

   always @(posedge clock) begin : watch
      reading_t seen;
      reading_t want;
      if (reset) begin
         for (int c = 0; c < NCH; c++) begin
            prime_ring(c, '0);
         end
         for (int c = 0; c < CAL_REGS; c++) begin
            cal[c] = '0;
         end
         cal_mask = '0;
         act_mask = ACTIVE_MASK_RST;
         dflt_dry = DEF_DRY_RST;
         dflt_wet = DEF_WET_RST;
         pending_readings.delete();
         failures <= 0;
      end else begin
         // Compare a returned reading with the oldest prediction.
         if (rsp_valid && rsp_ready) begin
            seen.valid_res = rsp_valid_res;
            seen.channel   = rsp_channel_out;
            seen.level     = rsp_filtered_level;
            seen.moisture  = rsp_moisture_x100;
            seen.bad_cal   = rsp_bad_calibration;
            seen.cls       = moisture_class_type'(rsp_moisture_class);
            seen.diag      = diagnosis_type'(rsp_diagnosis);
            if (pending_readings.size() == 0) begin
               if (failures < REPORT_MAX) begin
                  $display("%0t unexpected reading: %s", $realtime, describe(seen));
               end
               failures <= failures + 1;
            end else begin
               want = pending_readings.pop_front();
               if (seen !== want) begin
                  if (failures < REPORT_MAX) begin
                     $display("%0t reading mismatch", $realtime);
                     $display("   expected %s", describe(want));
                     $display("   actual   %s", describe(seen));
                  end
                  failures <= failures + 1;
               end
            end
         end

         // Register writes; the upper bits of narrow registers are dropped.
         if (csr_we) begin
            case (csr_index)
               REG_CAL_CH0, REG_CAL_CH1,
               REG_CAL_CH2, REG_CAL_CH3: cal[csr_index[1:0]] = csr_wdata;
               REG_CAL_MASK:    cal_mask = csr_wdata[MASK_W-1:0];
               REG_ACTIVE_MASK: act_mask = csr_wdata[MASK_W-1:0];
               REG_DEF_DRY:     dflt_dry = csr_wdata[CAL_W-1:0];
               REG_DEF_WET:     dflt_wet = csr_wdata[CAL_W-1:0];
               default: ;
            endcase
         end

         // An accepted item predicts one reading or, for an in-range channel, primes a ring.
         if (req_valid && req_ready) begin
            if (req_func == FUNC_SAMPLE) begin
               pending_readings.push_back(condition_sample(req_channel, req_sample));
            end else if (req_channel < NCH) begin
               prime_ring(req_channel, req_sample);
            end
         end
      end
      readings_due <= pending_readings.size();
   end

endmodule

// File: verif/tb_soil_moisture_channel_conditioner.sv
`timescale 1ns / 100ps

module tb_soil_moisture_channel_conditioner;
   import smcc_pkg::*;

   localparam int PHASES      = 10;
   localparam int PHASE_ITEMS = 108;
   localparam int TAIL_CYCLES = 30;

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_ready;
   logic               req_func;
   logic [CH_W-1:0]    req_channel;
   logic [SMP_W-1:0]   req_sample;
   logic               rsp_valid;
   logic               rsp_ready;
   logic               rsp_valid_res;
   logic [CH_W-1:0]    rsp_channel_out;
   logic [SMP_W-1:0]   rsp_filtered_level;
   logic [MOIST_W-1:0] rsp_moisture_x100;
   logic               rsp_bad_calibration;
   logic [CLASS_W-1:0] rsp_moisture_class;
   logic [DIAG_W-1:0]  rsp_diagnosis;
   logic               csr_we;
   logic [IDX_W-1:0]   csr_index;
   logic [CSR_W-1:0]   csr_wdata;

   int failures;
   int readings_due;
   bit sender_gaps;
   bit receiver_gaps;

   soil_moisture_channel_conditioner DUT (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_func            (req_func),
      .req_channel         (req_channel),
      .req_sample          (req_sample),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_valid_res       (rsp_valid_res),
      .rsp_channel_out     (rsp_channel_out),
      .rsp_filtered_level  (rsp_filtered_level),
      .rsp_moisture_x100   (rsp_moisture_x100),
      .rsp_bad_calibration (rsp_bad_calibration),
      .rsp_moisture_class  (rsp_moisture_class),
      .rsp_diagnosis       (rsp_diagnosis),
      .csr_we              (csr_we),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata)
   );

   smcc_reading_check reading_check (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_func            (req_func),
      .req_channel         (req_channel),
      .req_sample          (req_sample),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_valid_res       (rsp_valid_res),
      .rsp_channel_out     (rsp_channel_out),
      .rsp_filtered_level  (rsp_filtered_level),
      .rsp_moisture_x100   (rsp_moisture_x100),
      .rsp_bad_calibration (rsp_bad_calibration),
      .rsp_moisture_class  (rsp_moisture_class),
      .rsp_diagnosis       (rsp_diagnosis),
      .csr_we              (csr_we),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata),
      .failures            (failures),
      .readings_due        (readings_due)
   );

   initial begin
      clock = 1'b0;
   end

   always #5 clock = ~clock;

   // Hard stop in case the block hangs.
   initial begin
      #5_000_000;
      $display("tb: failure");
      $finish;
   end

   // Result side: stall at random while gaps are enabled.
   initial begin : drain_side
      int hold;
      hold = 0;
      rsp_ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold > 0) begin
            hold--;
            rsp_ready <= 1'b0;
         end else if (receiver_gaps && $urandom_range(0, 4) == 0) begin
            hold = $urandom_range(0, 5);
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // Present one item and hold it until the block takes it.
   task automatic offer_item(input logic func, input logic [CH_W-1:0] ch,
                             input logic [SMP_W-1:0] smp);
      if (sender_gaps && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_func    <= func;
      req_channel <= ch;
      req_sample  <= smp;
      do @(posedge clock); while (!req_ready);
   endtask

   // Stop sending and wait until every predicted reading has come back.
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (readings_due != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
   endtask

   task automatic put_csr(input logic [IDX_W-1:0] idx, input logic [CSR_W-1:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
   endtask

   // Rewrite every register once the block has gone quiet.
   task automatic reconfigure(input logic [CSR_W-1:0] cal0, input logic [CSR_W-1:0] cal1,
                              input logic [CSR_W-1:0] cal2, input logic [CSR_W-1:0] cal3,
                              input logic [MASK_W-1:0] cal_mask,
                              input logic [MASK_W-1:0] act_mask,
                              input logic [CAL_W-1:0] dry, input logic [CAL_W-1:0] wet);
      settle();
      put_csr(REG_CAL_CH0, cal0);
      put_csr(REG_CAL_CH1, cal1);
      put_csr(REG_CAL_CH2, cal2);
      put_csr(REG_CAL_CH3, cal3);
      put_csr(REG_CAL_MASK, CSR_W'(cal_mask));
      put_csr(REG_ACTIVE_MASK, CSR_W'(act_mask));
      put_csr(REG_DEF_DRY, CSR_W'(dry));
      put_csr(REG_DEF_WET, CSR_W'(wet));
      csr_we <= 1'b0;
   endtask

   // Dry/wet pair, mostly well formed, sometimes the full span or raw bits.
   function automatic logic [CSR_W-1:0] random_calibration();
      logic [CAL_W-1:0] dry;
      logic [CAL_W-1:0] wet;
      case ($urandom_range(0, 7))
         0: return CSR_W'($urandom);
         1: return {12'hFFF, 12'h000};
         default: begin
            dry = CAL_W'($urandom_range(1, 4095));
            wet = CAL_W'($urandom_range(0, dry - 1));
            return {dry, wet};
         end
      endcase
   endfunction

   // ADC reading biased toward the working band, with rail values now and then.
   function automatic logic [SMP_W-1:0] random_level();
      case ($urandom_range(0, 9))
         0: return $urandom_range(0, 1) ? 12'hFFF : 12'h000;
         1: return SMP_W'($urandom_range(4080, 4095));
         2: return SMP_W'($urandom_range(0, 15));
         3, 4, 5: return SMP_W'($urandom_range(0, 4095));
         default: return SMP_W'($urandom_range(800, 3600));
      endcase
   endfunction

   initial begin : stimulus
      logic [CSR_W-1:0]  dflt;
      logic [MASK_W-1:0] act;
      int                pause_at;
      reset         <= 1'b1;
      req_valid     <= 1'b0;
      req_func      <= FUNC_SAMPLE;
      req_channel   <= '0;
      req_sample    <= '0;
      csr_we        <= 1'b0;
      csr_index     <= REG_CAL_CH0;
      csr_wdata     <= '0;
      sender_gaps   = 1'b0;
      receiver_gaps = 1'b1;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Reset settings: empty ring reads as short and fully wet.
      offer_item(FUNC_SAMPLE, 2'd0, 12'd0);
      // Rail reading flags a disconnected probe.
      offer_item(FUNC_PRIME,  2'd1, 12'd4095);
      offer_item(FUNC_SAMPLE, 2'd1, 12'd4095);
      offer_item(FUNC_PRIME,  2'd2, 12'd2100);
      offer_item(FUNC_SAMPLE, 2'd2, 12'd2100);
      // Open-circuit threshold from just below and just at it.
      offer_item(FUNC_PRIME,  2'd3, 12'd4084);
      offer_item(FUNC_SAMPLE, 2'd3, 12'd4084);
      offer_item(FUNC_SAMPLE, 2'd3, 12'd4092);
      // Short threshold from both sides.
      offer_item(FUNC_PRIME,  2'd0, 12'd10);
      offer_item(FUNC_SAMPLE, 2'd0, 12'd10);
      offer_item(FUNC_PRIME,  2'd0, 12'd9);
      offer_item(FUNC_SAMPLE, 2'd0, 12'd9);
      // Moisture class thresholds under the default pair.
      offer_item(FUNC_PRIME,  2'd2, 12'd2640);
      offer_item(FUNC_SAMPLE, 2'd2, 12'd2640);
      offer_item(FUNC_PRIME,  2'd2, 12'd2280);
      offer_item(FUNC_SAMPLE, 2'd2, 12'd2280);
      offer_item(FUNC_PRIME,  2'd2, 12'd1740);
      offer_item(FUNC_SAMPLE, 2'd2, 12'd1740);
      offer_item(FUNC_PRIME,  2'd2, 12'd1380);
      offer_item(FUNC_SAMPLE, 2'd2, 12'd1380);

      // Calibrated channels, one inverted, one with wet equal to dry, one inactive.
      reconfigure({12'd3500, 12'd1000}, {12'd1000, 12'd3000}, {12'hFFF, 12'hFFF},
                  {12'hFFF, 12'h000}, 4'b0111, 4'b0111, 12'd3000, 12'd1200);
      offer_item(FUNC_SAMPLE, 2'd0, 12'd2000);
      offer_item(FUNC_SAMPLE, 2'd1, 12'd500);
      offer_item(FUNC_SAMPLE, 2'd2, 12'd4095);
      offer_item(FUNC_SAMPLE, 2'd3, 12'd100);
      // A prime on an inactive channel still fills its ring.
      offer_item(FUNC_PRIME,  2'd3, 12'd2047);

      // Inverted default pair on an uncalibrated channel reads dry without a flag.
      reconfigure({12'd3500, 12'd1000}, {12'd1000, 12'd3000}, {12'hFFF, 12'hFFF},
                  {12'hFFF, 12'h000}, 4'b1000, 4'b1111, 12'd1000, 12'd2000);
      offer_item(FUNC_SAMPLE, 2'd3, 12'd2047);
      offer_item(FUNC_SAMPLE, 2'd0, 12'd3000);

      // Random phases, each under fresh settings.
      for (int p = 0; p < PHASES; p++) begin
         dflt = ($urandom_range(0, 7) == 0) ? {DEF_DRY_RST, DEF_WET_RST}
                                            : random_calibration();
         act  = ($urandom_range(0, 3) == 0) ? MASK_W'($urandom) : 4'hF;
         reconfigure(random_calibration(), random_calibration(), random_calibration(),
                     random_calibration(), MASK_W'($urandom), act,
                     dflt[CSR_W-1:CAL_W], dflt[CAL_W-1:0]);
         sender_gaps   = (p < PHASES - 2) && ($urandom_range(0, 3) != 0);
         receiver_gaps = (p < PHASES - 2) && ($urandom_range(0, 3) != 0);
         pause_at = $urandom_range(20, PHASE_ITEMS - 20);
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            // Let the pipeline drain completely once per phase.
            if (i == pause_at) begin
               settle();
            end
            offer_item(($urandom_range(0, 9) == 0) ? FUNC_PRIME : FUNC_SAMPLE,
                       CH_W'($urandom_range(0, 3)), random_level());
         end
      end

      settle();
      if (failures == 0 && readings_due == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

// File: filelist.f
hdl/smcc_pkg.sv
hdl/smcc_ram.sv
hdl/smcc_div.sv
hdl/soil_moisture_channel_conditioner.sv
hdl/smcc_checker.sv
verif/smcc_reading_check.sv
verif/tb_soil_moisture_channel_conditioner.sv
